// ===== rtl/ascp_pkg.sv =====
// Package for the ASCII-to-CAN frame parser.
// Holds the framing characters, the hex digit decoder and the result type.
// Used by ascp_core and ascii_to_can_frame_parser.
package ascp_pkg;

	localparam logic [7:0] CH_START  = 8'h3A;
	localparam logic [7:0] CH_END    = 8'h3B;
	localparam logic [7:0] CH_STD    = 8'h53;
	localparam logic [7:0] CH_EXT    = 8'h58;
	localparam logic [7:0] CH_NORMAL = 8'h4E;
	localparam logic [7:0] CH_REMOTE = 8'h52;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_EIGHT  = 8'h38;

	localparam logic [4:0] STD_ID_END = 5'd5;
	localparam logic [4:0] EXT_ID_END = 5'd9;
	localparam logic [4:0] POS_MAX    = 5'd31;
	localparam logic [3:0] MAX_BYTES  = 4'd8;

	typedef struct packed {
		logic        frame_status;
		logic [28:0] can_id;
		logic        is_extended;
		logic        is_remote;
		logic [3:0]  data_length;
		logic [63:0] payload;
		logic [31:0] dropped_total;
	} ascp_result_t;

	// Returns {valid, nibble} for one ASCII hex digit.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				r = {1'b1, c[3:0]};
			end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
				r = {1'b1, c[3:0] + 4'd9};
			end
			return r;
		end
	endfunction

endpackage

// ===== rtl/ascp_core.sv =====
// Frame state and per-character decode of the ASCII-to-CAN frame parser.
// Consumes one character per advance and forms the result on the closing ';'.
// Depends on ascp_pkg.
module ascp_core
	import ascp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  logic [7:0]   rx_byte,
	output logic         emit,
	output ascp_result_t result
);

	typedef struct packed {
		logic [4:0]  char_pos;
		logic        extended;
		logic        remote;
		logic [31:0] id_accum;
		logic [63:0] data_accum;
		logic [3:0]  byte_count;
		logic [3:0]  half_digit;
		logic        digit_phase;
		logic        bad;
		logic [31:0] frame_len;
	} ascp_frame_t;

	logic        in_frame_q, in_frame_n;
	ascp_frame_t frame_q, frame_n;
	logic [31:0] drop_q, drop_n;
	logic [31:0] len_inc;
	logic [4:0]  id_end;
	logic [4:0]  pos;
	logic [4:0]  hex;
	logic        final_bad;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		end
	endfunction

	always_comb begin
		in_frame_n = in_frame_q;
		frame_n    = frame_q;
		drop_n     = drop_q;
		emit       = 1'b0;
		result     = '0;
		pos        = frame_q.char_pos;
		id_end     = frame_q.extended ? EXT_ID_END : STD_ID_END;
		hex        = hex_decode(rx_byte);
		len_inc    = (frame_q.frame_len != 32'hFFFF_FFFF) ? frame_q.frame_len + 32'd1
		                                                  : frame_q.frame_len;
		final_bad  = 1'b0;
		if (!in_frame_q) begin
			if (rx_byte == CH_START) begin
				frame_n           = '0;
				frame_n.char_pos  = 5'd1;
				frame_n.frame_len = 32'd1;
				in_frame_n        = 1'b1;
			end else begin
				drop_n = sat_add(drop_q, 32'd1);
			end
		end else begin
			frame_n.frame_len = len_inc;
			if (pos != POS_MAX) begin
				frame_n.char_pos = pos + 5'd1;
			end
			if (rx_byte != CH_END) begin
				if (!frame_q.bad) begin
					priority if (pos == 5'd1) begin
						if (rx_byte == CH_STD) begin
							frame_n.extended = 1'b0;
						end else if (rx_byte == CH_EXT) begin
							frame_n.extended = 1'b1;
						end else begin
							frame_n.bad = 1'b1;
						end
					end else if (pos <= id_end) begin
						if (hex[4]) begin
							frame_n.id_accum = {frame_q.id_accum[27:0], hex[3:0]};
						end else begin
							frame_n.bad = 1'b1;
						end
					end else if (pos == id_end + 5'd1) begin
						if (rx_byte == CH_NORMAL) begin
							frame_n.remote = 1'b0;
						end else if (rx_byte == CH_REMOTE) begin
							frame_n.remote = 1'b1;
						end else begin
							frame_n.bad = 1'b1;
						end
					end else if (frame_q.remote) begin
						if (frame_q.digit_phase || rx_byte < CH_ZERO || rx_byte > CH_EIGHT) begin
							frame_n.bad = 1'b1;
						end else begin
							frame_n.byte_count  = rx_byte[3:0];
							frame_n.digit_phase = 1'b1;
						end
					end else begin
						if (!hex[4]) begin
							frame_n.bad = 1'b1;
						end else if (!frame_q.digit_phase) begin
							frame_n.half_digit  = hex[3:0];
							frame_n.digit_phase = 1'b1;
						end else if (frame_q.byte_count >= MAX_BYTES) begin
							frame_n.bad = 1'b1;
						end else begin
							frame_n.data_accum[{~frame_q.byte_count[2:0], 3'b000} +: 8] =
								{frame_q.half_digit, hex[3:0]};
							frame_n.byte_count  = frame_q.byte_count + 4'd1;
							frame_n.digit_phase = 1'b0;
						end
					end
				end
			end else begin
				final_bad = frame_q.bad || (pos < id_end + 5'd2) ||
				            (frame_q.remote && !frame_q.digit_phase) ||
				            (!frame_q.remote && frame_q.digit_phase);
				emit = 1'b1;
				if (final_bad) begin
					drop_n              = sat_add(drop_q, len_inc);
					result.frame_status = 1'b1;
				end else begin
					result.can_id      = frame_q.extended ? frame_q.id_accum[31:3]
					                                      : {18'd0, frame_q.id_accum[15:5]};
					result.is_extended = frame_q.extended;
					result.is_remote   = frame_q.remote;
					result.data_length = frame_q.byte_count;
					result.payload     = frame_q.remote ? 64'd0 : frame_q.data_accum;
				end
				result.dropped_total = drop_n;
				in_frame_n           = 1'b0;
				frame_n              = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			frame_q    <= '0;
			drop_q     <= '0;
		end else if (advance) begin
			in_frame_q <= in_frame_n;
			frame_q    <= frame_n;
			drop_q     <= drop_n;
		end
	end

endmodule

// ===== rtl/ascii_to_can_frame_parser.sv =====
// Top level of the ASCII-to-CAN frame parser.
// Holds the input register, the result register and the handshakes.
// Depends on ascp_pkg and ascp_core.
//
// Input channel: in_valid, in_ready, rx_byte carry one received character per item.
// Output channel: out_valid, out_ready and the result fields carry one frame result.
// A frame runs from ':' to ';'; only the closing ';' produces a result item, either
// a decoded frame or a malformed status. Bytes outside frames are counted as drops.
// A closing ';' is decoded from the input register and its result is loaded into the
// result register, which drives out_valid, once that register is free.
// Throughput: one character per cycle unless a ';' waits for the result register,
// set by the single decode stage between the input register and the result register.
// A stalled receiver holds the result register; characters that produce no result
// keep flowing, and a closing ';' waits in the input register until the result
// register is free, with in_ready low while it waits.
// Reset clears the frame state and the drop count and empties both registers.
module ascii_to_can_frame_parser
	import ascp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_status,
	output logic [28:0] can_id,
	output logic        is_extended,
	output logic        is_remote,
	output logic [3:0]  data_length,
	output logic [63:0] payload,
	output logic [31:0] dropped_total
);

	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         advance;
	logic         emit;
	ascp_result_t result;
	ascp_result_t result_q;
	logic         out_valid_q;

	ascp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (rx_byte_s1),
		.emit    (emit),
		.result  (result)
	);

	assign advance  = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_status  = result_q.frame_status;
	assign can_id        = result_q.can_id;
	assign is_extended   = result_q.is_extended;
	assign is_remote     = result_q.is_remote;
	assign data_length   = result_q.data_length;
	assign payload       = result_q.payload;
	assign dropped_total = result_q.dropped_total;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> data_length <= MAX_BYTES)
		else $error("data length above eight bytes");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status |-> can_id == 29'd0 && payload == 64'd0 &&
			data_length == 4'd0 && !is_extended && !is_remote)
		else $error("malformed result carries frame fields");

	a_remote_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_status && is_remote |-> payload == 64'd0)
		else $error("remote frame result carries payload");

	a_std_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_status && !is_extended |-> can_id[28:11] == 18'd0)
		else $error("standard identifier wider than eleven bits");

endmodule

// ===== tb/sv/ascii_to_can_frame_parser_test.sv =====
// Self-checking testbench for ascii_to_can_frame_parser.
// Streams directed and random character traffic through a bursty sender and a stalling
// receiver, and checks every frame result against a cycle-free parser written here.
`timescale 1ns / 100ps

module ascii_to_can_frame_parser_test
	import ascp_pkg::*;
;

	localparam int RUN_LIMIT = 300000;
	localparam int STIM_CHARS = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        frame_status;
	logic [28:0] can_id;
	logic        is_extended;
	logic        is_remote;
	logic [3:0]  data_length;
	logic [63:0] payload;
	logic [31:0] dropped_total;

	ascii_to_can_frame_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_status(frame_status),
		.can_id(can_id),
		.is_extended(is_extended),
		.is_remote(is_remote),
		.data_length(data_length),
		.payload(payload),
		.dropped_total(dropped_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [7:0]   pending_chars[$];
	logic [7:0]   frame_buf[$];
	ascp_result_t results_due[$];
	int           errors = 0;
	int           cycles = 0;
	int           burst_left;
	int           gap_left;
	logic [9:0]   stall_ctr;

	// Parser state, mirrored one character at a time.
	logic        hunt_open;
	logic [4:0]  hunt_pos;
	logic        rx_ext;
	logic        rx_rtr;
	logic [31:0] id_bits;
	logic [63:0] data_bits;
	logic [3:0]  byte_total;
	logic [3:0]  high_nibble;
	logic        nibble_held;
	logic        frame_broken;
	logic [31:0] frame_chars;
	logic [31:0] drop_tally;

	function automatic int nibble_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	function automatic void count_drops(logic [31:0] n);
		logic [32:0] sum;
		sum = {1'b0, drop_tally} + {1'b0, n};
		drop_tally = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic void clear_frame();
		hunt_pos = '0;
		rx_ext = 1'b0;
		rx_rtr = 1'b0;
		id_bits = '0;
		data_bits = '0;
		byte_total = '0;
		high_nibble = '0;
		nibble_held = 1'b0;
		frame_broken = 1'b0;
		frame_chars = '0;
	endfunction

	task automatic parse_char(input logic [7:0] c);
		logic [4:0]   pos;
		logic [4:0]   id_end;
		int           nib;
		logic [63:0]  pair;
		ascp_result_t r;
		if (!hunt_open) begin
			if (c == CH_START) begin
				clear_frame();
				hunt_open = 1'b1;
				hunt_pos = 5'd1;
				frame_chars = 32'd1;
			end else begin
				count_drops(32'd1);
			end
			return;
		end
		if (frame_chars != 32'hFFFF_FFFF) frame_chars++;
		pos = hunt_pos;
		if (hunt_pos < POS_MAX) hunt_pos++;
		id_end = rx_ext ? EXT_ID_END : STD_ID_END;
		nib = nibble_of(c);
		if (c != CH_END) begin
			if (frame_broken) return;
			if (pos == 5'd1) begin
				if (c == CH_STD) rx_ext = 1'b0;
				else if (c == CH_EXT) rx_ext = 1'b1;
				else frame_broken = 1'b1;
			end else if (pos <= id_end) begin
				if (nib < 0) frame_broken = 1'b1;
				else id_bits = {id_bits[27:0], 4'(nib)};
			end else if (pos == id_end + 5'd1) begin
				if (c == CH_NORMAL) rx_rtr = 1'b0;
				else if (c == CH_REMOTE) rx_rtr = 1'b1;
				else frame_broken = 1'b1;
			end else if (rx_rtr) begin
				if (nibble_held || c < CH_ZERO || c > CH_EIGHT) begin
					frame_broken = 1'b1;
				end else begin
					byte_total = 4'(c - CH_ZERO);
					nibble_held = 1'b1;
				end
			end else if (nib < 0) begin
				frame_broken = 1'b1;
			end else if (!nibble_held) begin
				high_nibble = 4'(nib);
				nibble_held = 1'b1;
			end else if (byte_total >= MAX_BYTES) begin
				frame_broken = 1'b1;
			end else begin
				pair = {56'd0, high_nibble, 4'(nib)};
				data_bits |= pair << (56 - 8 * byte_total);
				byte_total++;
				nibble_held = 1'b0;
			end
			return;
		end
		if (!frame_broken) begin
			if (pos < id_end + 5'd2) frame_broken = 1'b1;
			else if (rx_rtr && !nibble_held) frame_broken = 1'b1;
			else if (!rx_rtr && nibble_held) frame_broken = 1'b1;
		end
		r = '0;
		if (frame_broken) begin
			count_drops(frame_chars);
			r.frame_status = 1'b1;
		end else begin
			r.can_id = rx_ext ? 29'(id_bits >> 3) : 29'(id_bits[15:0] >> 5);
			r.is_extended = rx_ext;
			r.is_remote = rx_rtr;
			r.data_length = byte_total;
			r.payload = rx_rtr ? 64'd0 : data_bits;
		end
		r.dropped_total = drop_tally;
		results_due.push_back(r);
		hunt_open = 1'b0;
		clear_frame();
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10) return CH_ZERO + v;
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
	endtask

	// Builds one frame into frame_buf; a remote length above 8 or nine data bytes is allowed.
	task automatic build_frame(input logic ext, input logic rtr, input logic [31:0] idv,
			input int n, input logic [63:0] dv);
		frame_buf.delete();
		frame_buf.push_back(CH_START);
		frame_buf.push_back(ext ? CH_EXT : CH_STD);
		for (int i = (ext ? 7 : 3); i >= 0; i--) frame_buf.push_back(hex_char(idv[4*i +: 4]));
		frame_buf.push_back(rtr ? CH_REMOTE : CH_NORMAL);
		if (rtr) begin
			frame_buf.push_back(CH_ZERO + 8'(n));
		end else begin
			for (int i = 0; i < n; i++) begin
				frame_buf.push_back(hex_char(dv[63 - 8 * (i % 8) -: 4]));
				frame_buf.push_back(hex_char(dv[59 - 8 * (i % 8) -: 4]));
			end
		end
		frame_buf.push_back(CH_END);
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_chars
		logic       next_valid;
		logic [7:0] next_char;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			burst_left = 0;
			gap_left = 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) parse_char(rx_byte);
			next_valid = 1'b0;
			next_char = rx_byte;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_chars.size() > 0) begin
				next_valid = 1'b1;
				next_char = pending_chars.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			in_valid <= next_valid;
			rx_byte <= next_char;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_ctr <= '0;
		end else begin
			stall_ctr <= stall_ctr + 10'd1;
			case (stall_ctr[9:8])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= stall_ctr[2];
			endcase
		end
	end

	always @(posedge clk) begin : watch_results
		ascp_result_t due;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0h drops %0h",
					$time, frame_status, dropped_total);
				errors++;
			end else begin
				due = results_due.pop_front();
				check_field("frame_status", due.frame_status, frame_status);
				check_field("can_id", due.can_id, can_id);
				check_field("is_extended", due.is_extended, is_extended);
				check_field("is_remote", due.is_remote, is_remote);
				check_field("data_length", due.data_length, data_length);
				check_field("payload", due.payload, payload);
				check_field("dropped_total", due.dropped_total, dropped_total);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == RUN_LIMIT) begin
			$display("ascii_to_can_frame_parser regression: fail");
			$finish;
		end
	end

	initial begin : run_test
		int          kind;
		int          k;
		logic [31:0] idv;
		logic [63:0] dv;
		hunt_open = 1'b0;
		clear_frame();
		drop_tally = '0;

		pending_chars.push_back(8'h00);
		pending_chars.push_back(8'hFF);
		pending_chars.push_back(CH_END);
		push_text(":S0000N;");
		push_text(":SFFFFNffffffffffffffff;");
		push_text(":XFFFFFFFFN0123456789abcdef;");
		push_text(":X00000000R0;");
		push_text(":SaBcDR8;");
		push_text(":S1234R9;");
		push_text(":S1234R;");
		push_text(":S1234R12;");
		push_text(":Q1234N;");
		push_text(":S1234Z;");
		push_text(":S12;");
		push_text(":;");
		push_text(":S1234N123;");
		push_text(":S1234N000102030405060708;");
		push_text(":S12:4N;");
		push_text(":S12G4N;");
		push_text(":S12g4N;");
		push_text(":X1234/67N;");
		push_text(":X1234@67N;");
		push_text(":X12345`7N;");
		push_text(":SFEDCNAa;");

		while (pending_chars.size() < STIM_CHARS) begin
			kind = $urandom_range(0, 99);
			idv = $urandom();
			dv = {$urandom(), $urandom()};
			if (kind < 85) begin
				if (kind < 60) build_frame(1'($urandom_range(0, 1)), 1'b0, idv,
					$urandom_range(0, 8), dv);
				else build_frame(1'($urandom_range(0, 1)), 1'b1, idv,
					$urandom_range(0, 8), dv);
				if (kind >= 75) begin
					k = $urandom_range(1, frame_buf.size() - 2);
					case ($urandom_range(0, 3))
						0: frame_buf[k] = 8'($urandom_range(0, 255));
						1: frame_buf.insert(k, hex_char(4'($urandom_range(0, 15))));
						2: frame_buf.delete(k);
						default: frame_buf.insert(k, CH_END);
					endcase
				end
			end else if (kind < 95) begin
				frame_buf.delete();
				repeat ($urandom_range(1, 5)) frame_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 2))
					0: build_frame(1'($urandom_range(0, 1)), 1'b0, idv, 9, dv);
					1: begin
						build_frame(1'($urandom_range(0, 1)), 1'b0, idv,
							$urandom_range(0, 7), dv);
						frame_buf.insert(frame_buf.size() - 1, hex_char(idv[3:0]));
					end
					default: begin
						frame_buf.delete();
						frame_buf.push_back(CH_START);
						repeat ($urandom_range(30, 45))
							frame_buf.push_back(8'($urandom_range(8'h3C, 8'h7E)));
						frame_buf.push_back(CH_END);
					end
				endcase
			end
			foreach (frame_buf[i]) pending_chars.push_back(frame_buf[i]);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || in_valid) @(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("ascii_to_can_frame_parser regression: pass");
		end else begin
			$display("ascii_to_can_frame_parser regression: fail");
		end
		$finish;
	end

endmodule

// ===== ascii_to_can_frame_parser.f =====
rtl/ascp_pkg.sv
rtl/ascp_core.sv
rtl/ascii_to_can_frame_parser.sv
tb/sv/ascii_to_can_frame_parser_test.sv
